// File: rtl/rau_pkg.sv
// Package for the rational arithmetic unit: widths, operation codes and shared types.
// Used by every module in rtl.
`timescale 1ns / 1ps
package rau_pkg;
  localparam int OPERAND_WIDTH = 32;
  localparam int WW = 64;
  localparam int GW = 7;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef struct packed {
    logic start;
    logic [WW-1:0] x;
    logic [WW-1:0] y;
  } gcd_req_t;

  typedef struct packed {
    logic done;
    logic [WW-1:0] g;
  } gcd_rsp_t;
endpackage

// File: rtl/rau_divider.sv
// Restoring divider, one quotient bit per cycle, 64-bit unsigned.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_divider
  import rau_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [WW-1:0] dividend,
  input  logic [WW-1:0] divisor,
  output logic          done,
  output logic [WW-1:0] quotient,
  output logic [WW-1:0] remainder
);
  logic [WW-1:0] q;
  logic [WW-1:0] r;
  logic [WW-1:0] d;
  logic [GW-1:0] cnt;
  logic          busy;
  logic [WW:0]   trial;

  assign trial = {r, q[WW-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == GW'(WW - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == GW'(WW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      // The remainder can carry one extra bit before the subtract.
      if (!trial[WW]) begin
        r <= trial[WW-1:0];
        q <= {q[WW-2:0], 1'b1};
      end else begin
        r <= {r[WW-2:0], q[WW-1]};
        q <= {q[WW-2:0], 1'b0};
      end
    end
  end

  assign quotient  = q;
  assign remainder = r;
endmodule

// File: rtl/rau_gcd.sv
// Binary gcd of two 64-bit unsigned values, one subtract and shift step per cycle.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_gcd
  import rau_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  gcd_req_t req,
  output gcd_rsp_t rsp
);
  logic [WW-1:0] u;
  logic [WW-1:0] v;
  logic [GW-1:0] k;
  logic          busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= !req.start && busy && (u == '0 || v == '0);
      if (req.start) begin
        busy <= 1'b1;
        u    <= req.x;
        v    <= req.y;
        k    <= '0;
      end else if (busy) begin
        if (u == '0 || v == '0) begin
          busy     <= 1'b0;
          rsp.g    <= (u | v) << k;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 1'b1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u >= v) begin
          u <= (u - v) >> 1;
        end else begin
          v <= (v - u) >> 1;
        end
      end
    end
  end
endmodule

// File: rtl/rational_arithmetic_unit_top.sv
// Top level of the rational arithmetic unit: sequencer, shared multiplier, gcd and divider.
// Depends on rau_pkg, rau_gcd and rau_divider.
`timescale 1ns / 1ps
// Usage: present command and the two raw fractions on the input channel with in_valid;
// the item is taken when in_ready is high. in_ready is low while an item is at work.
// Each operand is normalized (zero denominator becomes one, sign to the numerator,
// reduced by its gcd), the operation is applied with exact 64-bit products, and the
// result is reduced the same way. One result item leaves on the output channel.
// Work: three reductions (operand a, operand b, result), each a binary gcd plus two
// divisions by the gcd through the one shared divider, with the three multiply steps
// between the operand reductions and the result reduction.
// The next item is taken only once the result register is loaded and emptied, so items
// never overlap. A stalled receiver holds the result; the input stays closed.
// Reset clears the sequencer and drops any item at work.
module rational_arithmetic_unit_top
  import rau_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               command,
  input  logic signed [31:0]       a_num,
  input  logic signed [31:0]       a_den,
  input  logic signed [31:0]       b_num,
  input  logic signed [31:0]       b_den,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [63:0]       result_num,
  output logic [61:0]              result_den,
  output logic                     div_by_zero,
  output logic                     zero_den_fixed
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_LOAD  = 11'b00000000010,
    S_GCD   = 11'b00000000100,
    S_WGCD  = 11'b00000001000,
    S_DIVM  = 11'b00000010000,
    S_WDIVM = 11'b00000100000,
    S_WDIVD = 11'b00001000000,
    S_M1    = 11'b00010000000,
    S_M2    = 11'b00100000000,
    S_M3    = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state;
  logic [1:0] phase;        // 0 operand a, 1 operand b, 2 result
  logic [1:0] mstep;
  cmd_t cmd;
  logic [OPERAND_WIDTH-1:0] an, ad, bn, bd;
  logic a_neg, b_neg, r_neg, fixed, dz;
  logic [WW-1:0] a_mag, a_dn, b_mag, b_dn;
  logic [WW-1:0] cur_mag, cur_den, g;
  logic [WW-1:0] t1, t2;

  gcd_req_t greq;
  gcd_rsp_t grsp;
  logic dv_start, dv_done;
  logic [WW-1:0] dv_a, dv_q, dv_r;

  rau_gcd u_gcd (.clk(clk), .rst(rst), .req(greq), .rsp(grsp));
  rau_divider u_div (.clk(clk), .rst(rst), .start(dv_start), .dividend(dv_a), .divisor(g),
                     .done(dv_done), .quotient(dv_q), .remainder(dv_r));

  // Shared 32x32 multiplier; all operands after reduction fit in 32 bits.
  logic [31:0] mul_x, mul_y;
  logic [WW-1:0] mul_p;
  assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

  function automatic logic [WW-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
    logic [OPERAND_WIDTH-1:0] m;
    m = v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
    return WW'(m);
  endfunction

  always_comb begin
    mul_x = 32'd0;
    mul_y = 32'd0;
    case (mstep)
      2'd0: begin
        mul_x = a_mag[31:0];
        mul_y = (cmd == CMD_MUL) ? b_mag[31:0] : b_dn[31:0];
      end
      2'd1: begin
        mul_x = (cmd == CMD_DIV) ? a_dn[31:0] : b_mag[31:0];
        mul_y = (cmd == CMD_DIV) ? b_mag[31:0] : a_dn[31:0];
      end
      2'd2: begin
        mul_x = a_dn[31:0];
        mul_y = b_dn[31:0];
      end
      default: begin
        mul_x = 32'd0;
        mul_y = 32'd0;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign greq.start = (state == S_GCD);
  assign greq.x = cur_mag;
  assign greq.y = cur_den;
  assign dv_start = (state == S_DIVM) || (state == S_WDIVM && dv_done);
  assign dv_a = (state == S_DIVM) ? cur_mag : cur_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd   <= cmd_t'(command);
            an    <= a_num[OPERAND_WIDTH-1:0];
            ad    <= a_den[OPERAND_WIDTH-1:0];
            bn    <= b_num[OPERAND_WIDTH-1:0];
            bd    <= b_den[OPERAND_WIDTH-1:0];
            fixed <= 1'b0;
            dz    <= 1'b0;
            phase <= 2'd0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          // Normalize the operand for this phase. A zero denominator has a clear sign
          // bit, so the sign compare also covers the replaced denominator.
          if (phase == 2'd0) begin
            cur_mag <= mag_of(an);
            cur_den <= (ad == '0) ? WW'(1) : mag_of(ad);
            r_neg   <= (an[OPERAND_WIDTH-1] != ad[OPERAND_WIDTH-1]) && (an != '0);
            if (ad == '0) begin
              fixed <= 1'b1;
            end
          end else begin
            cur_mag <= mag_of(bn);
            cur_den <= (bd == '0) ? WW'(1) : mag_of(bd);
            r_neg   <= (bn[OPERAND_WIDTH-1] != bd[OPERAND_WIDTH-1]) && (bn != '0);
            if (bd == '0) begin
              fixed <= 1'b1;
            end
          end
          state <= S_GCD;
        end
        S_GCD: state <= S_WGCD;
        S_WGCD: begin
          if (grsp.done) begin
            g     <= grsp.g;
            state <= S_DIVM;
          end
        end
        S_DIVM: state <= S_WDIVM;
        S_WDIVM: begin
          if (dv_done) begin
            cur_mag <= dv_q;
            state   <= S_WDIVD;
          end
        end
        S_WDIVD: begin
          if (dv_done) begin
            if (phase == 2'd0) begin
              a_mag <= cur_mag;
              a_dn  <= dv_q;
              a_neg <= r_neg && (cur_mag != '0);
              phase <= 2'd1;
              state <= S_LOAD;
            end else if (phase == 2'd1) begin
              b_mag <= cur_mag;
              b_dn  <= dv_q;
              b_neg <= r_neg && (cur_mag != '0);
              mstep <= 2'd0;
              state <= S_M1;
            end else begin
              cur_den <= dv_q;
              r_neg   <= r_neg && (cur_mag != '0);
              state   <= S_OUT;
            end
          end
        end
        S_M1: begin
          t1    <= mul_p;
          mstep <= 2'd1;
          state <= S_M2;
        end
        S_M2: begin
          t2    <= mul_p;
          mstep <= 2'd2;
          state <= S_M3;
        end
        S_M3: begin
          phase <= 2'd2;
          case (cmd)
            CMD_ADD, CMD_SUB: begin
              cur_den <= mul_p;
              if (a_neg == (b_neg ^ (cmd == CMD_SUB))) begin
                cur_mag <= t1 + t2;
                r_neg   <= a_neg;
              end else if (t1 >= t2) begin
                cur_mag <= t1 - t2;
                r_neg   <= a_neg;
              end else begin
                cur_mag <= t2 - t1;
                r_neg   <= !a_neg;
              end
            end
            CMD_MUL: begin
              cur_den <= mul_p;
              cur_mag <= t1;
              r_neg   <= a_neg != b_neg;
            end
            default: begin
              if (b_mag == '0) begin
                dz      <= 1'b1;
                cur_mag <= '0;
                cur_den <= WW'(1);
                r_neg   <= 1'b0;
              end else begin
                cur_mag <= t1;
                cur_den <= t2;
                r_neg   <= a_neg != b_neg;
              end
            end
          endcase
          state <= S_GCD;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result_num = r_neg ? -$signed(cur_mag) : $signed(cur_mag);
  assign result_den = cur_den[61:0];
  assign div_by_zero = dz;
  assign zero_den_fixed = fixed;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(result_num)))
    else $error("result dropped under stall");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && div_by_zero) |-> (result_num == 64'sd0 && result_den == 62'd1))
    else $error("zero divisor result not 0/1");
  a_exact_div: assert property (@(posedge clk) disable iff (rst)
    ((state == S_WDIVM || state == S_WDIVD) && dv_done) |-> (dv_r == '0))
    else $error("division by the gcd left a remainder");
`endif
endmodule

// File: tb/rau_checker.sv
// Checker for the rational arithmetic unit: watches both channels, computes the
// expected reduced fraction for each accepted item and compares the results.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_checker
  import rau_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        command,
  input  logic [31:0]       a_num,
  input  logic [31:0]       a_den,
  input  logic [31:0]       b_num,
  input  logic [31:0]       b_den,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [63:0]       result_num,
  input  logic [61:0]       result_den,
  input  logic              div_by_zero,
  input  logic              zero_den_fixed,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    logic [63:0] num;
    logic [61:0] den;
    logic        dz;
    logic        fixed;
  } quotient_t;

  quotient_t answers[$];

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Sign and magnitude of an operand field; the most negative value stays exact.
  function automatic void split(input logic [31:0] v, output logic neg,
                                output logic [63:0] mag);
    neg = v[31];
    mag = neg ? {32'd0, -v} : {32'd0, v};
    if (neg && mag == 0) mag = 64'h8000_0000;
  endfunction

  function automatic void lowest_terms(inout logic neg, inout logic [63:0] mag,
                                       inout logic [63:0] den);
    logic [63:0] g;
    if (mag == 0) neg = 1'b0;
    g = gcd64(mag, den);
    if (g != 0) begin
      mag = mag / g;
      den = den / g;
    end
  endfunction

  function automatic void operand(input logic [31:0] n, input logic [31:0] d,
                                  inout logic fixed, output logic neg,
                                  output logic [63:0] mag, output logic [63:0] den);
    logic nn, dn;
    split(n, nn, mag);
    split(d, dn, den);
    if (den == 0) begin
      den = 1;
      dn = 1'b0;
      fixed = 1'b1;
    end
    neg = nn != dn;
    lowest_terms(neg, mag, den);
  endfunction

  function automatic quotient_t compute(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                                        logic [31:0] bn, logic [31:0] bd);
    quotient_t q;
    logic fixed, dz, an_neg, bn_neg, rn, s1, s2;
    logic [63:0] am, aden, bm, bden, rm, rd, t1, t2;
    fixed = 1'b0;
    dz = 1'b0;
    operand(an, ad, fixed, an_neg, am, aden);
    operand(bn, bd, fixed, bn_neg, bm, bden);
    rn = 1'b0;
    rm = 0;
    rd = 1;
    case (cmd_t'(op))
      CMD_ADD, CMD_SUB: begin
        t1 = am * bden;
        t2 = bm * aden;
        s1 = an_neg;
        s2 = (cmd_t'(op) == CMD_SUB) ? !bn_neg : bn_neg;
        if (s1 == s2) begin
          rm = t1 + t2;
          rn = s1;
        end else if (t1 >= t2) begin
          rm = t1 - t2;
          rn = s1;
        end else begin
          rm = t2 - t1;
          rn = s2;
        end
        rd = aden * bden;
      end
      CMD_MUL: begin
        rm = am * bm;
        rn = an_neg != bn_neg;
        rd = aden * bden;
      end
      default: begin
        if (bm == 0) begin
          dz = 1'b1;
        end else begin
          rm = am * bden;
          rd = aden * bm;
          rn = an_neg != bn_neg;
        end
      end
    endcase
    lowest_terms(rn, rm, rd);
    q.num = rn ? -rm : rm;
    q.den = rd[61:0];
    q.dz = dz;
    q.fixed = fixed;
    return q;
  endfunction

  assign pending = answers.size();

  always @(posedge clk) begin
    quotient_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        answers.push_back(compute(command, a_num, a_den, b_num, b_den));
      if (out_valid && out_ready) begin
        if (answers.size() == 0) begin
          $error("result with no item waiting");
          fail_count <= fail_count + 1;
        end else begin
          want = answers.pop_front();
          if (result_num !== want.num || result_den !== want.den ||
              div_by_zero !== want.dz || zero_den_fixed !== want.fixed) begin
            fail_count <= fail_count + 1;
            if (result_num !== want.num)
              $error("result_num expected %0d got %0d", $signed(want.num),
                     $signed(result_num));
            if (result_den !== want.den)
              $error("result_den expected %0d got %0d", want.den, result_den);
            if (div_by_zero !== want.dz)
              $error("div_by_zero expected %0b got %0b", want.dz, div_by_zero);
            if (zero_den_fixed !== want.fixed)
              $error("zero_den_fixed expected %0b got %0b", want.fixed, zero_den_fixed);
          end
        end
      end
    end
  end

endmodule

// File: tb/tb_top.sv
// Testbench top for the rational arithmetic unit: clock, reset, stimulus, verdict.
// Depends on rau_pkg, rational_arithmetic_unit_top and rau_checker.
`timescale 1ns / 1ps
module tb_top;
  import rau_pkg::*;

  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = '0;
  logic [31:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] result_num;
  logic [61:0] result_den;
  logic div_by_zero, zero_den_fixed;
  int fail_count, pending;
  int send_idle = 6, take_idle = 78;

  always #5 clk = ~clk;

  rational_arithmetic_unit_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_ready(out_ready), .result_num(result_num),
    .result_den(result_den), .div_by_zero(div_by_zero), .zero_den_fixed(zero_den_fixed)
  );

  rau_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_ready(out_ready), .result_num(result_num),
    .result_den(result_den), .div_by_zero(div_by_zero), .zero_den_fixed(zero_den_fixed),
    .fail_count(fail_count), .pending(pending)
  );

  // The receiver stalls at random; the idle share changes between phases.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= take_idle);
  end

  // Mostly small magnitudes so that reductions do real work, sometimes full range.
  function automatic logic [31:0] pick();
    case ($urandom_range(7))
      0: return $urandom;
      1: return MOST_NEG;
      2: return 32'd0;
      3: return MOST_POS;
      default: return 32'($signed($urandom_range(200)) - 100);
    endcase
  endfunction

  // Valid stays high from one item to the next unless the sender idles.
  task automatic send(cmd_t op, logic [31:0] an, logic [31:0] ad,
                      logic [31:0] bn, logic [31:0] bd);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= op;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    #2_000_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    int n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: every operation, extremes, zero denominators, zero divisor.
    for (int op = 0; op < 4; op++) begin
      send(cmd_t'(op), 32'd1, 32'd2, 32'd1, 32'd3);
      send(cmd_t'(op), MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
      send(cmd_t'(op), MOST_POS, MOST_NEG, MOST_NEG, MOST_POS);
      send(cmd_t'(op), 32'd5, 32'd0, -32'sd6, -32'sd4);
    end
    send(CMD_DIV, 32'd3, 32'd4, 32'd0, 32'd7);
    send(CMD_DIV, 32'd3, 32'd0, 32'd0, 32'd0);
    send(CMD_MUL, 32'd0, -32'sd5, 32'd7, 32'd3);
    send(CMD_SUB, 32'd2, 32'd4, 32'd1, 32'd2);
    send(CMD_ADD, MOST_POS, 32'd1, MOST_POS, 32'd1);
    send(CMD_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 6 : (phase == 1) ? 78 : 0;
      take_idle = (phase == 0) ? 78 : (phase == 1) ? 6 : 0;
      n = (phase == 2) ? 450 : 440;
      repeat (n) send(cmd_t'($urandom_range(3)), pick(), pick(), pick(), pick());
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    if (fail_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
